// File: hw/rtl/index_list_to_csr_builder_macros.svh
// Assertion helpers used by the checker of the CSR builder.
`ifndef INDEX_LIST_TO_CSR_BUILDER_MACROS_SVH
`define INDEX_LIST_TO_CSR_BUILDER_MACROS_SVH

// Same-cycle implication.
`define ICB_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error(msg);

// Next-cycle implication.
`define ICB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
      else $error(msg);

`endif

// File: hw/rtl/icb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package icb_pkg;

   // Fixed field widths
   localparam int REQ_W    = 2;
   localparam int BIDX_W   = 10;
   localparam int QIDX_W   = 11;
   localparam int STATUS_W = 3;
   localparam int VALUE_W  = 11;
   localparam int CSR_W    = 9;
   // Element store entry: no-bucket mark on top of the bucket number
   localparam int ELEM_W   = BIDX_W + 1;

   // Request codes
   localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_START = 2'd1;
   localparam logic [REQ_W-1:0] REQ_REF   = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_ACCEPTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_DONE      = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_BAD_QUERY = 3'd4;

   typedef struct packed {
      logic [REQ_W-1:0]  req_type;
      logic [BIDX_W-1:0] bucket_index;
      logic              no_bucket;
      logic              last_element;
      logic [QIDX_W-1:0] query_index;
   } icb_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  read_value;
   } icb_rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_PREFIX,
      ST_SCAT_E,
      ST_SCAT_C,
      ST_SCAT_W
   } icb_state_type;

   typedef enum logic [1:0] {
      ERR_NONE,
      ERR_RANGE,
      ERR_FULL
   } icb_err_type;

   typedef enum logic [1:0] {
      SRC_NONE,
      SRC_START,
      SRC_REF
   } icb_src_type;

   // Memory port enables from the sequencer
   typedef struct packed {
      logic elem_wr;
      logic elem_rd;
      logic cnt_wr;
      logic cnt_rd;
      logic start_wr;
      logic start_rd;
      logic ref_wr;
      logic ref_rd;
   } icb_ctl_type;

endpackage

`default_nettype wire

// File: hw/rtl/icb_count_bank.sv
`timescale 1ns / 1ps
`default_nettype none

// Histogram/cursor memory and bucket start memory
module icb_count_bank #(
   parameter int MAX_ELEMENTS = 1024,
   parameter int MAX_BUCKETS  = 256
) (
   input  wire logic                clock,
   input  wire icb_pkg::icb_ctl_type ctl,
   input  wire logic [BW-1:0]       cnt_rd_addr,
   input  wire logic [BW-1:0]       cnt_wr_addr,
   input  wire logic [CW-1:0]       cnt_wr_data,
   input  wire logic [SW-1:0]       start_rd_addr,
   input  wire logic [SW-1:0]       start_wr_addr,
   input  wire logic [CW-1:0]       start_wr_data,
   output logic      [CW-1:0]       cnt_q,
   output logic      [CW-1:0]       start_q
);

   localparam int CW = $clog2(MAX_ELEMENTS + 1);
   localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int SW = $clog2(MAX_BUCKETS + 1);

   logic [CW-1:0] cnt_mem   [MAX_BUCKETS];
   logic [CW-1:0] start_mem [MAX_BUCKETS + 1];

   // count / cursor memory
   always_ff @(posedge clock) begin
      if (ctl.cnt_wr) begin
         cnt_mem[cnt_wr_addr] <= cnt_wr_data;
      end
      if (ctl.cnt_rd) begin
         cnt_q <= cnt_mem[cnt_rd_addr];
      end
   end

   // bucket start memory
   always_ff @(posedge clock) begin
      if (ctl.start_wr) begin
         start_mem[start_wr_addr] <= start_wr_data;
      end
      if (ctl.start_rd) begin
         start_q <= start_mem[start_rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/icb_elem_bank.sv
`timescale 1ns / 1ps
`default_nettype none

// Per-element bucket store and reference list
module icb_elem_bank #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  wire logic                   clock,
   input  wire icb_pkg::icb_ctl_type    ctl,
   input  wire logic [EW-1:0]          elem_rd_addr,
   input  wire logic [EW-1:0]          elem_wr_addr,
   input  wire logic [icb_pkg::ELEM_W-1:0] elem_wr_data,
   input  wire logic [EW-1:0]          ref_rd_addr,
   input  wire logic [EW-1:0]          ref_wr_addr,
   input  wire logic [EW-1:0]          ref_wr_data,
   output logic      [icb_pkg::ELEM_W-1:0] elem_q,
   output logic      [EW-1:0]          ref_q
);

   localparam int EW = $clog2(MAX_ELEMENTS);

   logic [icb_pkg::ELEM_W-1:0] elem_mem [MAX_ELEMENTS];
   logic [EW-1:0]              ref_mem  [MAX_ELEMENTS];

   // element bucket store
   always_ff @(posedge clock) begin
      if (ctl.elem_wr) begin
         elem_mem[elem_wr_addr] <= elem_wr_data;
      end
      if (ctl.elem_rd) begin
         elem_q <= elem_mem[elem_rd_addr];
      end
   end

   // reference list
   always_ff @(posedge clock) begin
      if (ctl.ref_wr) begin
         ref_mem[ref_wr_addr] <= ref_wr_data;
      end
      if (ctl.ref_rd) begin
         ref_q <= ref_mem[ref_rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/index_list_to_csr_builder.sv
// Loads and queries: an accepted request passes the exec state, which registers its
// result; the next request is taken only after that, and not while a result stalls.
// Last load of a good build: prefix walk over B buckets (B = latched bucket count),
// scatter of every element, then a histogram clear over B entries. A failed
// build ends with the histogram clear. Requests stall meanwhile. Reset (synchronous)
// clears control state, then all MAX_BUCKETS histogram entries, before any request.
`timescale 1ns / 1ps
`default_nettype none

module index_list_to_csr_builder #(
   parameter int MAX_ELEMENTS = 1024,
   parameter int MAX_BUCKETS  = 256
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire icb_pkg::icb_req_type        req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output icb_pkg::icb_rsp_type             rsp_data,
   input  wire logic                       csr_wr_en,
   input  wire logic [icb_pkg::CSR_W-1:0]  csr_wr_data
);

   localparam int CW = $clog2(MAX_ELEMENTS + 1);
   localparam int EW = $clog2(MAX_ELEMENTS);
   localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int SW = $clog2(MAX_BUCKETS + 1);
   localparam int WW = (SW > CW) ? SW : CW;

   // state and control registers
   icb_pkg::icb_state_type state_ff, state_in;
   icb_pkg::icb_err_type   err_ff, err_in;
   icb_pkg::icb_src_type   src_ff, src_in;
   logic [icb_pkg::CSR_W-1:0]    csr_ff;
   logic [WW-1:0]                walk_ff, walk_in;
   logic [CW-1:0]                loaded_ff, loaded_in;
   logic [SW-1:0]                bb_ff, bb_in;
   logic [SW-1:0]                clr_lim_ff, clr_lim_in;
   logic                         built_valid_ff, built_valid_in;
   logic [SW-1:0]                built_buckets_ff, built_buckets_in;
   logic [CW-1:0]                built_refs_ff, built_refs_in;
   logic                         inc_ff, inc_in;
   logic                         build_ff, build_in;
   logic                         clear_ff, clear_in;
   logic                         pf_vld_ff, pf_vld_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   // payload registers
   logic [icb_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [BW-1:0]                inc_addr_ff, inc_addr_in;
   logic [BW-1:0]                pf_addr_ff, pf_addr_in;
   logic [BW-1:0]                scat_bkt_ff, scat_bkt_in;
   logic [CW-1:0]                sum_ff, sum_in;
   icb_pkg::icb_rsp_type          rsp_data_ff, rsp_data_in;

   // memory ports
   icb_pkg::icb_ctl_type          ctl;
   logic [BW-1:0]                cnt_rd_addr, cnt_wr_addr;
   logic [CW-1:0]                cnt_wr_data, cnt_q;
   logic [SW-1:0]                start_rd_addr, start_wr_addr;
   logic [CW-1:0]                start_wr_data, start_q;
   logic [EW-1:0]                elem_rd_addr, elem_wr_addr;
   logic [icb_pkg::ELEM_W-1:0]   elem_wr_data, elem_q;
   logic [EW-1:0]                ref_rd_addr, ref_wr_addr, ref_wr_data, ref_q;

   // decode of the incoming beat
   logic                         req_accept;
   logic                         new_build;
   logic [SW-1:0]                bb_clip, bb_eff;
   logic                         store_ok, range_bad, count_ok;
   icb_pkg::icb_err_type          err_load;
   logic                         start_ok, ref_ok;
   // walk conditions
   logic                         walk_lt_bb, walk_lt_loaded, walk_lt_lim;
   logic                         pf_done, elem_nob;

   icb_count_bank #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .MAX_BUCKETS  (MAX_BUCKETS)
   ) u_count_bank (
      .clock         (clock),
      .ctl           (ctl),
      .cnt_rd_addr   (cnt_rd_addr),
      .cnt_wr_addr   (cnt_wr_addr),
      .cnt_wr_data   (cnt_wr_data),
      .start_rd_addr (start_rd_addr),
      .start_wr_addr (start_wr_addr),
      .start_wr_data (start_wr_data),
      .cnt_q         (cnt_q),
      .start_q       (start_q)
   );

   icb_elem_bank #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_elem_bank (
      .clock        (clock),
      .ctl          (ctl),
      .elem_rd_addr (elem_rd_addr),
      .elem_wr_addr (elem_wr_addr),
      .elem_wr_data (elem_wr_data),
      .ref_rd_addr  (ref_rd_addr),
      .ref_wr_addr  (ref_wr_addr),
      .ref_wr_data  (ref_wr_data),
      .elem_q       (elem_q),
      .ref_q        (ref_q)
   );

   // beat decode
   always_comb begin
      req_accept = req_valid && !req_stall;
      new_build  = (loaded_ff == '0) && (err_ff == icb_pkg::ERR_NONE);
      bb_clip    = (32'(csr_ff) < MAX_BUCKETS) ? SW'(csr_ff) : SW'(MAX_BUCKETS);
      bb_eff     = new_build ? bb_clip : bb_ff;
      store_ok   = (err_ff == icb_pkg::ERR_NONE) && (32'(loaded_ff) < MAX_ELEMENTS);
      range_bad  = 32'(req_data.bucket_index) >= 32'(bb_eff);
      count_ok   = store_ok && !req_data.no_bucket && !range_bad;
      if (err_ff != icb_pkg::ERR_NONE) begin
         err_load = err_ff;
      end else if (!store_ok) begin
         err_load = icb_pkg::ERR_FULL;
      end else if (!req_data.no_bucket && range_bad) begin
         err_load = icb_pkg::ERR_RANGE;
      end else begin
         err_load = icb_pkg::ERR_NONE;
      end
      start_ok = built_valid_ff && (32'(req_data.query_index) <= 32'(built_buckets_ff));
      ref_ok   = built_valid_ff && (32'(req_data.query_index) < 32'(built_refs_ff))
                 && (32'(req_data.query_index) < MAX_ELEMENTS);
   end

   // walk conditions
   always_comb begin
      walk_lt_bb     = walk_ff < WW'(bb_ff);
      walk_lt_loaded = walk_ff < WW'(loaded_ff);
      walk_lt_lim    = walk_ff < WW'(clr_lim_ff);
      pf_done        = !walk_lt_bb && !pf_vld_ff;
      elem_nob       = elem_q[icb_pkg::ELEM_W-1];
   end

   // next state
   always_comb begin
      case (state_ff)
         icb_pkg::ST_CLEAR: begin
            state_in = walk_lt_lim ? icb_pkg::ST_CLEAR : icb_pkg::ST_IDLE;
         end
         icb_pkg::ST_IDLE: begin
            state_in = req_accept ? icb_pkg::ST_EXEC : icb_pkg::ST_IDLE;
         end
         icb_pkg::ST_EXEC: begin
            if (build_ff) begin
               state_in = icb_pkg::ST_PREFIX;
            end else if (clear_ff) begin
               state_in = icb_pkg::ST_CLEAR;
            end else begin
               state_in = icb_pkg::ST_IDLE;
            end
         end
         icb_pkg::ST_PREFIX: begin
            state_in = pf_done ? icb_pkg::ST_SCAT_E : icb_pkg::ST_PREFIX;
         end
         icb_pkg::ST_SCAT_E: begin
            state_in = walk_lt_loaded ? icb_pkg::ST_SCAT_C : icb_pkg::ST_CLEAR;
         end
         icb_pkg::ST_SCAT_C: begin
            state_in = elem_nob ? icb_pkg::ST_SCAT_E : icb_pkg::ST_SCAT_W;
         end
         icb_pkg::ST_SCAT_W: begin
            state_in = icb_pkg::ST_SCAT_E;
         end
         default: begin
            state_in = icb_pkg::ST_CLEAR;
         end
      endcase
   end

   // memory port controls and stall
   always_comb begin
      ctl           = '0;
      cnt_rd_addr   = '0;
      cnt_wr_addr   = '0;
      cnt_wr_data   = '0;
      start_rd_addr = '0;
      start_wr_addr = '0;
      start_wr_data = '0;
      elem_rd_addr  = '0;
      elem_wr_addr  = '0;
      elem_wr_data  = '0;
      ref_rd_addr   = '0;
      ref_wr_addr   = '0;
      ref_wr_data   = '0;
      req_stall     = !((state_ff == icb_pkg::ST_IDLE) && (!rsp_valid_ff || !rsp_stall));
      case (state_ff)
         icb_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (req_data.req_type)
                  icb_pkg::REQ_LOAD: begin
                     // store element, fetch its bucket count
                     ctl.elem_wr  = store_ok;
                     elem_wr_addr = EW'(loaded_ff);
                     elem_wr_data = {req_data.no_bucket,
                                     req_data.no_bucket ? {icb_pkg::BIDX_W{1'b0}}
                                                        : req_data.bucket_index};
                     ctl.cnt_rd   = count_ok;
                     cnt_rd_addr  = BW'(req_data.bucket_index);
                  end
                  icb_pkg::REQ_START: begin
                     ctl.start_rd  = start_ok;
                     start_rd_addr = SW'(req_data.query_index);
                  end
                  icb_pkg::REQ_REF: begin
                     ctl.ref_rd  = ref_ok;
                     ref_rd_addr = EW'(req_data.query_index);
                  end
                  default: begin
                     ctl = '0;
                  end
               endcase
            end
         end
         icb_pkg::ST_EXEC: begin
            // histogram write-back; first start of a build is zero
            ctl.cnt_wr    = inc_ff;
            cnt_wr_addr   = inc_addr_ff;
            cnt_wr_data   = cnt_q + CW'(1);
            ctl.start_wr  = build_ff;
            start_wr_addr = '0;
            start_wr_data = '0;
         end
         icb_pkg::ST_PREFIX: begin
            // read next count; write start and cursor of the previous bucket
            ctl.cnt_rd    = walk_lt_bb;
            cnt_rd_addr   = BW'(walk_ff);
            ctl.start_wr  = pf_vld_ff;
            start_wr_addr = SW'(pf_addr_ff) + SW'(1);
            start_wr_data = sum_ff + cnt_q;
            ctl.cnt_wr    = pf_vld_ff;
            cnt_wr_addr   = pf_addr_ff;
            cnt_wr_data   = sum_ff;
         end
         icb_pkg::ST_SCAT_E: begin
            ctl.elem_rd  = walk_lt_loaded;
            elem_rd_addr = EW'(walk_ff);
         end
         icb_pkg::ST_SCAT_C: begin
            ctl.cnt_rd  = !elem_nob;
            cnt_rd_addr = BW'(elem_q[icb_pkg::BIDX_W-1:0]);
         end
         icb_pkg::ST_SCAT_W: begin
            // place element at the cursor, bump the cursor
            ctl.ref_wr  = 1'b1;
            ref_wr_addr = EW'(cnt_q);
            ref_wr_data = EW'(walk_ff);
            ctl.cnt_wr  = 1'b1;
            cnt_wr_addr = scat_bkt_ff;
            cnt_wr_data = cnt_q + CW'(1);
         end
         icb_pkg::ST_CLEAR: begin
            ctl.cnt_wr  = walk_lt_lim;
            cnt_wr_addr = BW'(walk_ff);
            cnt_wr_data = '0;
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

   // register next values
   always_comb begin
      walk_in          = walk_ff;
      loaded_in        = loaded_ff;
      err_in           = err_ff;
      bb_in            = bb_ff;
      clr_lim_in       = clr_lim_ff;
      built_valid_in   = built_valid_ff;
      built_buckets_in = built_buckets_ff;
      built_refs_in    = built_refs_ff;
      inc_in           = inc_ff;
      build_in         = build_ff;
      clear_in         = clear_ff;
      pf_vld_in        = pf_vld_ff;
      src_in           = src_ff;
      status_in        = status_ff;
      inc_addr_in      = inc_addr_ff;
      pf_addr_in       = pf_addr_ff;
      scat_bkt_in      = scat_bkt_ff;
      sum_in           = sum_ff;
      rsp_data_in      = rsp_data_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      case (state_ff)
         icb_pkg::ST_IDLE: begin
            if (req_accept) begin
               inc_in   = 1'b0;
               build_in = 1'b0;
               clear_in = 1'b0;
               src_in   = icb_pkg::SRC_NONE;
               case (req_data.req_type)
                  icb_pkg::REQ_LOAD: begin
                     if (new_build) begin
                        bb_in          = bb_eff;
                        built_valid_in = 1'b0;
                     end
                     loaded_in   = store_ok ? loaded_ff + CW'(1) : loaded_ff;
                     err_in      = err_load;
                     inc_in      = count_ok;
                     inc_addr_in = BW'(req_data.bucket_index);
                     case (err_load)
                        icb_pkg::ERR_RANGE: status_in = icb_pkg::STATUS_RANGE;
                        icb_pkg::ERR_FULL:  status_in = icb_pkg::STATUS_OVERFLOW;
                        default:            status_in = icb_pkg::STATUS_ACCEPTED;
                     endcase
                     // end of build: prefix and scatter if good, else clear
                     if (req_data.last_element) begin
                        err_in = icb_pkg::ERR_NONE;
                        if (err_load == icb_pkg::ERR_NONE) begin
                           status_in = icb_pkg::STATUS_DONE;
                           build_in  = 1'b1;
                        end else begin
                           loaded_in = '0;
                           clear_in  = 1'b1;
                        end
                     end
                  end
                  icb_pkg::REQ_START: begin
                     status_in = start_ok ? icb_pkg::STATUS_ACCEPTED
                                          : icb_pkg::STATUS_BAD_QUERY;
                     src_in    = start_ok ? icb_pkg::SRC_START : icb_pkg::SRC_NONE;
                  end
                  icb_pkg::REQ_REF: begin
                     status_in = ref_ok ? icb_pkg::STATUS_ACCEPTED
                                        : icb_pkg::STATUS_BAD_QUERY;
                     src_in    = ref_ok ? icb_pkg::SRC_REF : icb_pkg::SRC_NONE;
                  end
                  default: begin
                     status_in = icb_pkg::STATUS_BAD_QUERY;
                  end
               endcase
            end
         end
         icb_pkg::ST_EXEC: begin
            rsp_valid_in       = 1'b1;
            rsp_data_in.status = status_ff;
            case (src_ff)
               icb_pkg::SRC_START: rsp_data_in.read_value = icb_pkg::VALUE_W'(start_q);
               icb_pkg::SRC_REF:   rsp_data_in.read_value = icb_pkg::VALUE_W'(ref_q);
               default:            rsp_data_in.read_value = '0;
            endcase
            walk_in   = '0;
            sum_in    = '0;
            pf_vld_in = 1'b0;
            if (clear_ff) begin
               clr_lim_in = bb_ff;
            end
         end
         icb_pkg::ST_PREFIX: begin
            pf_vld_in  = walk_lt_bb;
            pf_addr_in = BW'(walk_ff);
            if (walk_lt_bb) begin
               walk_in = walk_ff + WW'(1);
            end
            if (pf_vld_ff) begin
               sum_in = sum_ff + cnt_q;
            end
            if (pf_done) begin
               walk_in          = '0;
               built_buckets_in = bb_ff;
               built_refs_in    = sum_ff;
            end
         end
         icb_pkg::ST_SCAT_E: begin
            // scatter finished: publish the build, then clear the histogram
            if (!walk_lt_loaded) begin
               walk_in        = '0;
               clr_lim_in     = bb_ff;
               loaded_in      = '0;
               built_valid_in = 1'b1;
            end
         end
         icb_pkg::ST_SCAT_C: begin
            scat_bkt_in = BW'(elem_q[icb_pkg::BIDX_W-1:0]);
            if (elem_nob) begin
               walk_in = walk_ff + WW'(1);
            end
         end
         icb_pkg::ST_SCAT_W: begin
            walk_in = walk_ff + WW'(1);
         end
         icb_pkg::ST_CLEAR: begin
            if (walk_lt_lim) begin
               walk_in = walk_ff + WW'(1);
            end
         end
         default: begin
            walk_in = walk_ff;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= icb_pkg::ST_CLEAR;
         walk_ff          <= '0;
         clr_lim_ff       <= SW'(MAX_BUCKETS);
         csr_ff           <= '0;
         loaded_ff        <= '0;
         err_ff           <= icb_pkg::ERR_NONE;
         bb_ff            <= '0;
         built_valid_ff   <= 1'b0;
         built_buckets_ff <= '0;
         built_refs_ff    <= '0;
         inc_ff           <= 1'b0;
         build_ff         <= 1'b0;
         clear_ff         <= 1'b0;
         pf_vld_ff        <= 1'b0;
         src_ff           <= icb_pkg::SRC_NONE;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         walk_ff          <= walk_in;
         clr_lim_ff       <= clr_lim_in;
         if (csr_wr_en) begin
            csr_ff <= csr_wr_data;
         end
         loaded_ff        <= loaded_in;
         err_ff           <= err_in;
         bb_ff            <= bb_in;
         built_valid_ff   <= built_valid_in;
         built_buckets_ff <= built_buckets_in;
         built_refs_ff    <= built_refs_in;
         inc_ff           <= inc_in;
         build_ff         <= build_in;
         clear_ff         <= clear_in;
         pf_vld_ff        <= pf_vld_in;
         src_ff           <= src_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      inc_addr_ff <= inc_addr_in;
      pf_addr_ff  <= pf_addr_in;
      scat_bkt_ff <= scat_bkt_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/icb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "index_list_to_csr_builder_macros.svh"

module icb_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_stall,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire icb_pkg::icb_rsp_type  rsp_data
);

   // a stalled result beat holds
   `ICB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "result beat changed while stalled")

   // every accepted beat is answered by a result beat
   `ICB_ASSERT_IMPLY(a_rsp_follows, clock, reset, req_valid && !req_stall, ##2 rsp_valid, "accepted beat not answered in time")

   // no new beat while a result is stuck in the output register
   `ICB_ASSERT_IMPLY(a_no_overrun, clock, reset, rsp_valid && rsp_stall, req_stall, "request taken while result stalled")

   // only a result with status accepted carries a value
   `ICB_ASSERT_IMPLY(a_value_zero, clock, reset, rsp_valid && (rsp_data.status != icb_pkg::STATUS_ACCEPTED), rsp_data.read_value == '0, "nonzero value on non-query result")

   // histogram clear runs right after reset
   `ICB_ASSERT_IMPLY(a_clear_after_reset, clock, reset, $past(reset), req_stall, "request taken during reset clear")

endmodule

bind index_list_to_csr_builder icb_checker u_icb_checker (.*);

`default_nettype wire

// File: verif/tb_index_list_to_csr_builder.sv
`timescale 1ns / 1ps

module tb_index_list_to_csr_builder;
   import icb_pkg::*;

   localparam int MAX_ELEMS   = 1024;
   localparam int MAX_BKTS    = 256;
   localparam int ITEM_TARGET = 1850;
   // Worst build: prefix walk, scatter of every element, histogram clear
   localparam int BUILD_LAT   = 3700;
   localparam int LONG_HOLD   = 250;
   localparam int WATCHDOG    = 20000;
   // Request code with no operation behind it
   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   icb_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   icb_rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [CSR_W-1:0] csr_wr_data = '0;

   index_list_to_csr_builder #(
      .MAX_ELEMENTS(MAX_ELEMS),
      .MAX_BUCKETS (MAX_BKTS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // ---------------------------------------------------------------
   // CSR map predictor state
   // ---------------------------------------------------------------
   logic [CSR_W-1:0]   bucket_cfg;
   logic [ELEM_W-1:0]  elem_mem  [MAX_ELEMS];
   logic [VALUE_W-1:0] hist      [MAX_BKTS];
   logic [VALUE_W-1:0] start_mem [MAX_BKTS+1];
   logic [BIDX_W-1:0]  ref_mem   [MAX_ELEMS];
   int unsigned        n_loaded;
   icb_err_type        build_fault;
   int unsigned        latched_bkts;
   bit                 good_build;
   int unsigned        good_bkts;
   int unsigned        good_refs;

   icb_req_type pending_req_q[$];
   icb_rsp_type expected_rsp_q[$];
   int          fail_count = 0;
   int          items_made = 0;
   int          long_hold_req = 0;
   bit          tail_quiet = 1'b0;

   task automatic csr_map_reset();
      bucket_cfg   = '0;
      for (int i = 0; i < MAX_ELEMS; i++) begin
         elem_mem[i] = '0;
         ref_mem[i]  = '0;
      end
      for (int i = 0; i < MAX_BKTS; i++) hist[i] = '0;
      for (int i = 0; i <= MAX_BKTS; i++) start_mem[i] = '0;
      n_loaded     = 0;
      build_fault  = ERR_NONE;
      latched_bkts = 0;
      good_build   = 1'b0;
      good_bkts    = 0;
      good_refs    = 0;
   endtask

   // One request in, one response out; updates the map state
   function automatic icb_rsp_type csr_map_step(icb_req_type r);
      icb_rsp_type o;
      int unsigned sum;
      int unsigned pos;
      int unsigned k;
      o.status     = STATUS_ACCEPTED;
      o.read_value = '0;
      if (r.req_type == REQ_LOAD) begin
         // first load of a build latches the bucket count and hides the old map
         if (n_loaded == 0 && build_fault == ERR_NONE) begin
            good_build   = 1'b0;
            latched_bkts = (bucket_cfg < MAX_BKTS) ? bucket_cfg : MAX_BKTS;
         end
         if (build_fault == ERR_NONE) begin
            if (n_loaded >= MAX_ELEMS) begin
               build_fault = ERR_FULL;
            end else begin
               elem_mem[n_loaded] = r.no_bucket ? {1'b1, {BIDX_W{1'b0}}}
                                                : {1'b0, r.bucket_index};
               n_loaded++;
               if (!r.no_bucket) begin
                  if (r.bucket_index >= latched_bkts) build_fault = ERR_RANGE;
                  else hist[r.bucket_index] = hist[r.bucket_index] + 1'b1;
               end
            end
         end
         if (build_fault == ERR_RANGE) o.status = STATUS_RANGE;
         else if (build_fault == ERR_FULL) o.status = STATUS_OVERFLOW;
         if (r.last_element) begin
            if (build_fault == ERR_NONE) begin
               // exclusive prefix sum, histogram reused as fill counters
               sum = 0;
               start_mem[0] = '0;
               for (k = 0; k < latched_bkts; k++) begin
                  sum = sum + hist[k];
                  start_mem[k+1] = VALUE_W'(sum);
                  hist[k] = '0;
               end
               // stable scatter of element positions
               for (int unsigned e = 0; e < n_loaded; e++) begin
                  if (!elem_mem[e][BIDX_W]) begin
                     k = elem_mem[e][BIDX_W-1:0];
                     if (k < latched_bkts) begin
                        pos = start_mem[k] + hist[k];
                        hist[k] = hist[k] + 1'b1;
                        if (pos < MAX_ELEMS) ref_mem[pos] = BIDX_W'(e);
                     end
                  end
               end
               good_bkts  = latched_bkts;
               good_refs  = sum;
               good_build = 1'b1;
               o.status   = STATUS_DONE;
            end
            n_loaded    = 0;
            build_fault = ERR_NONE;
            for (k = 0; k < MAX_BKTS; k++) hist[k] = '0;
         end
      end else if (r.req_type == REQ_START && good_build && r.query_index <= good_bkts) begin
         o.read_value = start_mem[r.query_index];
      end else if (r.req_type == REQ_REF && good_build && r.query_index < good_refs
                   && r.query_index < MAX_ELEMS) begin
         o.read_value = {1'b0, ref_mem[r.query_index]};
      end else begin
         o.status = STATUS_BAD_QUERY;
      end
      return o;
   endfunction

   // ---------------------------------------------------------------
   // Request driver: predicts on every accepted beat
   // ---------------------------------------------------------------
   int send_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && !req_stall) expected_rsp_q.push_back(csr_map_step(req_data));
         if (!req_valid || !req_stall) begin
            if (send_gap != 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_req_q.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= pending_req_q.pop_front();
               if (!tail_quiet && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 8);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Response stall: random bursts, plus one long hold on request
   // ---------------------------------------------------------------
   int stall_left = 0;
   int hold_left  = 0;
   int hold_seen  = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
         hold_left  <= 0;
         hold_seen  <= 0;
      end else if (hold_seen != long_hold_req) begin
         hold_seen <= long_hold_req;
         hold_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (!tail_quiet && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 7);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // Response monitor
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      icb_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp_q.size() == 0) begin
            $error("unexpected beat: status %0d read_value %0d",
                   rsp_data.status, rsp_data.read_value);
            fail_count++;
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.read_value !== want.read_value) begin
               $error("read_value: expected %0d, got %0d",
                      want.read_value, rsp_data.read_value);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Watchdog: cycles with work outstanding and no beat moving
   // ---------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (!req_valid && pending_req_q.size() == 0 && expected_rsp_q.size() == 0)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   task automatic push_item(input logic [REQ_W-1:0] kind, input int unsigned bkt,
                            input bit nob, input bit last, input int unsigned q);
      icb_req_type r;
      r.req_type     = kind;
      r.bucket_index = BIDX_W'(bkt);
      r.no_bucket    = nob;
      r.last_element = last;
      r.query_index  = QIDX_W'(q);
      pending_req_q.push_back(r);
      items_made++;
   endtask

   // Wait until nothing is queued, in flight or expected
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_req_q.size() != 0 || req_valid || expected_rsp_q.size() != 0);
   endtask

   // Drain, let any build walk finish, then set the bucket count
   task automatic start_phase(input logic [CSR_W-1:0] cfg);
      wait_drained();
      repeat (BUILD_LAT) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cfg;
      bucket_cfg   = cfg;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(negedge clock);
   endtask

   // A build of n loads, optionally with one out-of-range bucket
   task automatic gen_build(input int n, input int unsigned bkts, input bit fault);
      int  fault_pos;
      bit  nob;
      int unsigned bkt;
      fault_pos = fault ? $urandom_range(0, n - 1) : n;
      for (int i = 0; i < n; i++) begin
         if (i == fault_pos) begin
            nob = 1'b0;
            bkt = $urandom_range(bkts, 1023);
         end else begin
            nob = ($urandom_range(0, 7) == 0);
            if (nob || bkts == 0) bkt = $urandom_range(0, 1023);
            else bkt = $urandom_range(0, bkts - 1);
         end
         push_item(REQ_LOAD, bkt, nob, i == n - 1, $urandom_range(0, 1024));
      end
   endtask

   // Start and reference reads, mostly in range, and some unused request codes
   task automatic gen_queries(input int m, input int unsigned bkts, input int unsigned n_hint);
      int pick;
      int unsigned q;
      logic [REQ_W-1:0] kind;
      for (int i = 0; i < m; i++) begin
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            kind = REQ_START;
            q = ($urandom_range(0, 4) == 0) ? $urandom_range(bkts + 1, 1024)
                                            : $urandom_range(0, bkts);
         end else if (pick < 9) begin
            kind = REQ_REF;
            q = ($urandom_range(0, 4) == 0) ? $urandom_range(n_hint, 1024)
                                            : $urandom_range(0, n_hint - 1);
         end else begin
            kind = REQ_UNUSED;
            q = $urandom_range(0, 1024);
         end
         push_item(kind, $urandom_range(0, 1023), $urandom_range(0, 1),
                   $urandom_range(0, 1), q);
      end
   endtask

   task automatic gen_noise(input int k);
      for (int i = 0; i < k; i++)
         push_item($urandom_range(0, 3), $urandom_range(0, 1023), $urandom_range(0, 1),
                   $urandom_range(0, 1), $urandom_range(0, 1024));
   endtask

   task automatic run_rounds(input logic [CSR_W-1:0] cfg, input int rounds);
      int unsigned bkts;
      int n;
      start_phase(cfg);
      bkts = (cfg > MAX_BKTS) ? MAX_BKTS : cfg;
      for (int i = 0; i < rounds; i++) begin
         n = $urandom_range(1, 24);
         gen_build(n, bkts, $urandom_range(0, 4) == 0);
         gen_queries($urandom_range(3, 14), bkts, n);
         if ($urandom_range(0, 5) == 0) gen_noise($urandom_range(1, 3));
      end
   endtask

   // ---------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------
   initial begin
      csr_map_reset();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // zero buckets: queries before any build, empty build, range error
      start_phase(9'd0);
      push_item(REQ_START, 0, 1'b0, 1'b0, 0);
      push_item(REQ_UNUSED, 1023, 1'b1, 1'b1, 2047);
      push_item(REQ_LOAD, 1023, 1'b1, 1'b1, 0);
      push_item(REQ_START, 0, 1'b0, 1'b0, 0);
      push_item(REQ_REF, 0, 1'b0, 1'b0, 0);
      push_item(REQ_LOAD, 0, 1'b0, 1'b1, 0);

      // four buckets: good build, edge queries, then a failed build
      start_phase(9'd4);
      push_item(REQ_LOAD, 3, 1'b0, 1'b0, 0);
      push_item(REQ_LOAD, 0, 1'b0, 1'b0, 0);
      push_item(REQ_LOAD, 0, 1'b1, 1'b0, 0);
      push_item(REQ_LOAD, 3, 1'b0, 1'b0, 0);
      push_item(REQ_LOAD, 1, 1'b0, 1'b1, 0);
      push_item(REQ_START, 0, 1'b0, 1'b0, 0);
      push_item(REQ_START, 0, 1'b0, 1'b0, 2);
      push_item(REQ_START, 0, 1'b0, 1'b0, 4);
      push_item(REQ_START, 0, 1'b0, 1'b0, 5);
      push_item(REQ_REF, 0, 1'b0, 1'b0, 0);
      push_item(REQ_REF, 0, 1'b0, 1'b0, 3);
      push_item(REQ_REF, 0, 1'b0, 1'b0, 4);
      push_item(REQ_REF, 0, 1'b0, 1'b0, 1024);
      // out-of-range bucket, then a load under the held error
      push_item(REQ_LOAD, 2, 1'b0, 1'b0, 0);
      push_item(REQ_LOAD, 1023, 1'b0, 1'b0, 0);
      push_item(REQ_LOAD, 1, 1'b0, 1'b1, 0);
      push_item(REQ_START, 0, 1'b0, 1'b0, 0);

      // top of the register range (clipped) and a single bucket
      run_rounds(9'd511, 6);
      run_rounds(9'd1, 6);

      // store overflow while the receiver holds off
      start_phase(9'd256);
      long_hold_req <= long_hold_req + 1;
      gen_build(MAX_ELEMS + 2, MAX_BKTS, 1'b0);
      gen_queries(8, MAX_BKTS, 16);

      // one larger good build with many reads
      start_phase(9'd300);
      gen_build(200, MAX_BKTS, 1'b0);
      gen_queries(40, MAX_BKTS, 200);

      while (items_made < ITEM_TARGET - 150) run_rounds($urandom_range(0, 511), 6);

      // closing stretch with both sides running flat out
      tail_quiet <= 1'b1;
      run_rounds($urandom_range(2, 256), 5);

      wait_drained();
      repeat (BUILD_LAT) @(posedge clock);
      if (fail_count == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

endmodule
